// File: rtl/tlsr_pkg.sv
// Shared codes and types for the tile layer smoothing renderer.
// No dependencies; imported by the renderer core.
package tlsr_pkg;

  // Memory select codes carried by load requests
  localparam logic [2:0] MEM_TEXT_RAM = 3'd0;
  localparam logic [2:0] MEM_BG_RAM   = 3'd1;
  localparam logic [2:0] MEM_TEXT_GFX = 3'd2;
  localparam logic [2:0] MEM_BG_GFX   = 3'd3;
  localparam logic [2:0] MEM_SMOOTH   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCROLL_X  = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y  = 2'd1;
  localparam logic [1:0] CFG_TEXT_BANK = 2'd2;
  localparam logic [1:0] CFG_SMOOTH    = 2'd3;

  // Request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef logic [3:0] colour_t;
  typedef logic [1:0] text_col_t;

endpackage

// File: rtl/tile_layer_smoothing_renderer_core.sv
// Tile layer renderer core: scrolled background with smoothing plus text overlay.
// Depends on tlsr_pkg for memory select codes, register indexes and types.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per cycle while in_stall
//   is low: a load request writes one entry into a tile RAM, graphics ROM or
//   smoothing PROM; a render request gives one pixel pair in raster order.
//   Output channel (out_valid / out_stall) returns one pixel pair per render
//   request; load requests return nothing.
//   Configuration channel (cfg_valid / cfg_ready) is always ready and writes
//   scroll, text bank and smoothing page registers; write it only when idle.
// Pipeline:
//   Four stages of synchronous memory reads (tile RAM, graphics ROM, horizontal
//   PROM, vertical PROM) are chained, and the vertical PROM read registers the
//   result. One request is taken per cycle unless a result waits under out_stall.
//   Line store reads are forwarded from the two stages that write behind them.
// Reset:
//   Clears configuration, pipeline valid bits, the previous column colour and
//   the line store valid bits (line store reads as zero). Loaded memories keep
//   no reset value. A render request with frame start clears the line store valid bits.
// Stall:
//   While a result waits under out_stall the whole pipeline holds and in_stall
//   is raised; nothing is lost or repeated.
module tile_layer_smoothing_renderer_core
  import tlsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [2:0]  mem_select,
  input  logic [15:0] load_address,
  input  logic [7:0]  load_data,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  pixel_left,
  output logic [9:0]  pixel_right
);

  // Configuration registers
  logic [8:0] scroll_x;
  logic [8:0] scroll_y;
  logic       text_bank;
  logic [1:0] smoothing_select;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x         <= '0;
      scroll_y         <= '0;
      text_bank        <= 1'b0;
      smoothing_select <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCROLL_X:  scroll_x <= cfg_data;
        CFG_SCROLL_Y:  scroll_y <= cfg_data;
        CFG_TEXT_BANK: text_bank <= cfg_data[0];
        CFG_SMOOTH:    smoothing_select <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // Pipeline advance: hold everything while a result waits
  logic en;
  logic take;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign take     = in_valid && en;

  // Stage 0: scrolled position and tile RAM addresses
  logic [8:0] sx0;
  logic [8:0] sy0;
  logic [9:0] bg_offs;
  assign sx0     = {pixel_x[8:1], 1'b0} + scroll_x;
  assign sy0     = {1'b0, pixel_y} + scroll_y;
  assign bg_offs = {sy0[8:4], sx0[8:4]};

  logic [7:0] text_tile_ram [2048];
  logic [7:0] bg_tile_ram   [2048];
  logic [7:0] txt_q;
  logic [7:0] code_q;
  logic [7:0] attr_q;

  // Text tile RAM: write loads, read tile code
  always_ff @(posedge clk) begin
    if (en) begin
      if (take && func == FUNC_LOAD && mem_select == MEM_TEXT_RAM &&
          load_address[15:11] == '0) begin
        text_tile_ram[load_address[10:0]] <= load_data;
      end
      txt_q <= text_tile_ram[{pixel_y[7:3], pixel_x[8:3]}];
    end
  end

  // Background tile RAM: write loads, read code and attribute
  always_ff @(posedge clk) begin
    if (en) begin
      if (take && func == FUNC_LOAD && mem_select == MEM_BG_RAM &&
          load_address[15:11] == '0) begin
        bg_tile_ram[load_address[10:0]] <= load_data;
      end
      code_q <= bg_tile_ram[{1'b0, bg_offs}];
      attr_q <= bg_tile_ram[{1'b1, bg_offs}];
    end
  end

  // Stage 1 registers
  logic        s1_valid;
  logic        s1_func;
  logic [2:0]  s1_sel;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;
  logic [7:0]  s1_row;
  logic [2:0]  s1_y3;
  logic [3:0]  s1_sx;
  logic [2:0]  s1_sy;
  logic        s1_fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func <= func;
      s1_sel  <= mem_select;
      s1_addr <= load_address;
      s1_data <= load_data;
      s1_row  <= pixel_x[8:1];
      s1_y3   <= pixel_y[2:0];
      s1_sx   <= sx0[3:0];
      s1_sy   <= sy0[3:1];
      s1_fs   <= frame_start;
    end
  end

  // Stage 1: tile codes, flip and graphics addresses
  logic [10:0] bg_code;
  logic [3:0]  sxf;
  logic [14:0] gfx_offs;
  logic [12:0] txg_addr;
  assign bg_code  = {attr_q[1], attr_q[3], attr_q[0], code_q};
  assign sxf      = s1_sx ^ {4{attr_q[2]}};
  assign gfx_offs = {bg_code, s1_sy, sxf[3]};
  assign txg_addr = {text_bank, txt_q, s1_y3, s1_row[1]};

  logic [7:0] text_gfx_rom [8192];
  logic [7:0] bg_gfx_rom   [65536];
  logic [7:0] line_store   [256];
  logic [7:0] txg_q;
  logic [7:0] d1_q;
  logic [7:0] d2_q;
  logic [7:0] ls_q;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid && s1_func == FUNC_LOAD && s1_sel == MEM_TEXT_GFX &&
          s1_addr[15:13] == '0) begin
        text_gfx_rom[s1_addr[12:0]] <= s1_data;
      end
      txg_q <= text_gfx_rom[txg_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid && s1_func == FUNC_LOAD && s1_sel == MEM_BG_GFX) begin
        bg_gfx_rom[s1_addr] <= s1_data;
      end
      d1_q <= bg_gfx_rom[{1'b0, gfx_offs}];
      d2_q <= bg_gfx_rom[{1'b1, gfx_offs}];
    end
  end

  // Stage 2 registers
  logic        s2_valid;
  logic        s2_func;
  logic [2:0]  s2_sel;
  logic [15:0] s2_addr;
  logic [7:0]  s2_data;
  logic [7:0]  s2_row;
  logic [1:0]  s2_sxs;
  logic        s2_fs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_func <= s1_func;
      s2_sel  <= s1_sel;
      s2_addr <= s1_addr;
      s2_data <= s1_data;
      s2_row  <= s1_row;
      s2_sxs  <= sxf[2:1];
      s2_fs   <= s1_fs;
    end
  end

  // Stage 3 and 4 registers used for forwarding
  logic        s3_valid;
  logic        s3_func;
  logic [2:0]  s3_sel;
  logic [15:0] s3_addr;
  logic [7:0]  s3_data;
  logic [7:0]  s3_row;
  colour_t     s3_bg;
  text_col_t   s3_col1;
  text_col_t   s3_col2;
  logic [7:0]  s3_ls;
  logic        s3_fs;
  logic        s3_render;
  colour_t     hp_q;
  logic [7:0]  s4_row;
  logic [7:0]  s4_pair;
  text_col_t   s4_col1;
  text_col_t   s4_col2;
  colour_t     vl_q;
  colour_t     vr_q;

  assign s3_render = s3_valid && s3_func == FUNC_RENDER;

  // Stage 2: background pixel, text colour, previous column
  logic        s2_render;
  logic [1:0]  sidx;
  colour_t     bg_col;
  text_col_t   col1;
  text_col_t   col2;
  colour_t     prev_column_colour;
  colour_t     prev_eff;
  logic [255:0] ls_valid;
  logic [7:0]  ls_fwd;

  assign s2_render = s2_valid && s2_func == FUNC_RENDER;
  assign sidx      = ~s2_sxs;
  assign bg_col    = {d1_q[{1'b1, sidx}], d1_q[{1'b0, sidx}],
                      d2_q[{1'b1, sidx}], d2_q[{1'b0, sidx}]};
  assign col1      = s2_row[0] ? txg_q[3:2] : txg_q[7:6];
  assign col2      = s2_row[0] ? txg_q[1:0] : txg_q[5:4];
  assign prev_eff  = (s2_row == '0) ? '0 : prev_column_colour;

  // Resolve line store pair: newest writer first, respecting frame clears
  always_comb begin
    if (s2_fs) begin
      ls_fwd = '0;
    end else if (s3_render && s3_row == s2_row) begin
      ls_fwd = {s3_bg, hp_q};
    end else if (s3_render && s3_fs) begin
      ls_fwd = ls_valid[s2_row] ? ls_q : '0;
    end else if (out_valid && s4_row == s2_row) begin
      ls_fwd = s4_pair;
    end else begin
      ls_fwd = ls_valid[s2_row] ? ls_q : '0;
    end
  end

  // Hold the last background colour for the next pair
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_column_colour <= '0;
    end else if (en && s2_render) begin
      prev_column_colour <= bg_col;
    end
  end

  // Line store valid bits: frame start clears, writes set
  always_ff @(posedge clk) begin
    if (rst) begin
      ls_valid <= '0;
    end else if (en) begin
      if (s2_render && s2_fs) begin
        ls_valid <= '0;
      end else if (s3_render) begin
        ls_valid[s3_row] <= 1'b1;
      end
    end
  end

  // Line store: read pair at stage 1, write pair at stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_render) begin
        line_store[s3_row] <= {s3_bg, hp_q};
      end
      ls_q <= line_store[s1_row];
    end
  end

  // Horizontal smoothing PROM
  colour_t hprom [1024];

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_valid && s2_func == FUNC_LOAD && s2_sel == MEM_SMOOTH &&
          s2_addr[15:10] == '0) begin
        hprom[s2_addr[9:0]] <= s2_data[3:0];
      end
      hp_q <= hprom[{smoothing_select, prev_eff, bg_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_func <= s2_func;
      s3_sel  <= s2_sel;
      s3_addr <= s2_addr;
      s3_data <= s2_data;
      s3_row  <= s2_row;
      s3_bg   <= bg_col;
      s3_col1 <= col1;
      s3_col2 <= col2;
      s3_ls   <= ls_fwd;
      s3_fs   <= s2_fs;
    end
  end

  // Stage 3: vertical smoothing PROM, both pixels
  colour_t vprom [1024];

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_valid && s3_func == FUNC_LOAD && s3_sel == MEM_SMOOTH &&
          s3_addr[15:11] == '0 && s3_addr[10]) begin
        vprom[s3_addr[9:0]] <= s3_data[3:0];
      end
      vl_q <= vprom[{smoothing_select, s3_ls[3:0], hp_q}];
      vr_q <= vprom[{smoothing_select, s3_ls[7:4], s3_bg}];
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_render;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_row  <= s3_row;
      s4_pair <= {s3_bg, hp_q};
      s4_col1 <= s3_col1;
      s4_col2 <= s3_col2;
    end
  end

  assign pixel_left  = {s4_col1, 4'b0000, vl_q};
  assign pixel_right = {s4_col2, 4'b0000, vr_q};

endmodule
